FILE: rtl/spmsu_pkg.sv
`default_nettype none
package spmsu_pkg;

  localparam int AXES   = 64;
  localparam int ADDR_W = (AXES > 1) ? $clog2(AXES) : 1;

  // input kinds
  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_POWER   = 2'd2;
  localparam logic [1:0] CMD_MOTION  = 2'd3;

  // motion modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SPIN = 2'd1;

  // config register indexes
  localparam logic [7:0] REG_MOTION_MODE = 8'd0;
  localparam logic [7:0] REG_SPIN_DELTA  = 8'd1;
  localparam logic [7:0] REG_SPIN_UPPER  = 8'd2;
  localparam logic [7:0] REG_SPIN_MARGIN = 8'd3;

  // power phases
  localparam logic [2:0] PH_RESET    = 3'd1;
  localparam logic [2:0] PH_SHUTDOWN = 3'd2;
  localparam logic [2:0] PH_SWITCHON = 3'd3;
  localparam logic [2:0] PH_ENABLE   = 3'd4;
  localparam logic [2:0] PH_SPIN     = 3'd5;

  // controlwords
  localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
  localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
  localparam logic [15:0] CW_ENABLE      = 16'h000f;

  localparam logic [31:0] DEADBAND_MASK = 32'hffff_fff0;
  localparam logic [31:0] BACKOFF       = 32'd10;
  localparam logic [7:0]  OPMODE_SPIN   = 8'd8;

  localparam logic [10:0] STEP_LAST      = 11'd1200;
  localparam logic [10:0] STEP_RESET_END = 11'd400;
  localparam logic [10:0] STEP_SHUT_END  = 11'd600;
  localparam logic [10:0] STEP_SWON_END  = 11'd800;
  localparam logic [10:0] STEP_EN_END    = 11'd1000;

  typedef struct packed {
    logic [31:0] target;
    logic [15:0] control;
    logic [7:0]  op_mode;
    logic        reverse;
    logic [2:0]  phase;
  } axis_entry_t;

  localparam int ENTRY_W = $bits(axis_entry_t);

  typedef struct packed {
    logic [1:0]  motion_mode;
    logic [15:0] spin_delta;
    logic [30:0] spin_upper;
    logic [15:0] spin_margin;
  } cfg_t;

  function automatic logic [ADDR_W-1:0] axis_addr(input logic [5:0] axis);
    return ADDR_W'(axis);
  endfunction

  function automatic logic axis_in_range(input logic [5:0] axis);
    return (32'(axis) < AXES);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/spmsu_ram.sv
`default_nettype none
module spmsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/spmsu_update.sv
`default_nettype none
module spmsu_update
  import spmsu_pkg::*;
(
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] actual,
  input  wire logic [10:0] step,
  input  wire cfg_t        cfg,
  input  wire axis_entry_t old_entry,
  output axis_entry_t      new_entry
);

  logic signed [33:0] up_sum;
  logic               up_turn;
  logic               down_turn;
  logic               below_backoff;
  logic [31:0]        back_pos;

  assign up_sum = $signed({{2{actual[31]}}, actual}) + $signed({18'd0, cfg.spin_margin});
  assign up_turn = up_sum >= $signed({3'd0, cfg.spin_upper});
  assign down_turn = $signed({actual[31], actual}) <= $signed({17'd0, cfg.spin_margin});
  assign below_backoff = $signed(actual) < $signed(BACKOFF);
  assign back_pos = actual - BACKOFF;

  always_comb begin
    new_entry = old_entry;
    case (cmd)
      CMD_POWER: begin
        if (step <= STEP_RESET_END) begin
          new_entry.control = CW_FAULT_RESET;
          new_entry.phase   = PH_RESET;
          new_entry.target  = '0;
        end else if (step <= STEP_SHUT_END) begin
          new_entry.control = CW_SHUTDOWN;
          new_entry.phase   = PH_SHUTDOWN;
          new_entry.target  = actual;
        end else if (step <= STEP_SWON_END) begin
          new_entry.control = CW_SWITCH_ON;
          new_entry.phase   = PH_SWITCHON;
          new_entry.target  = actual;
        end else if (step <= STEP_EN_END) begin
          new_entry.control = CW_ENABLE;
          new_entry.phase   = PH_ENABLE;
          new_entry.target  = actual;
        end
      end
      CMD_MOTION: begin
        if (cfg.motion_mode == MODE_IDLE) begin
          if ((old_entry.target & DEADBAND_MASK) != (actual & DEADBAND_MASK)) begin
            new_entry.target = actual;
          end
        end else if (cfg.motion_mode == MODE_SPIN) begin
          new_entry.phase   = PH_SPIN;
          new_entry.control = CW_ENABLE;
          new_entry.op_mode = OPMODE_SPIN;
          if (!old_entry.reverse) begin
            if (up_turn) begin
              new_entry.target  = back_pos;
              new_entry.reverse = 1'b1;
            end else begin
              new_entry.target = actual + {16'd0, cfg.spin_delta};
            end
          end else begin
            if (down_turn) begin
              new_entry.reverse = 1'b0;
              new_entry.target  = below_backoff ? '0 : back_pos;
            end else begin
              new_entry.target = actual - {16'd0, cfg.spin_delta};
            end
          end
        end
      end
      default: begin
        new_entry = old_entry;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/servo_power_up_and_motion_sequencer_unit.sv
`default_nettype none
// Flow: an accepted word is registered in stage 1 while its RAM read is
//   in flight, then moves to the output register once that register is free.
// Throughput: one word per cycle sustained while m_tready holds; the per-axis
//   read-modify-write (RAM read in the accept cycle, update and write-back
//   as stage 1 advances) is covered by a one-entry forward of the last write-back.
// Reset (rst, synchronous, active high): step counter, config registers, the
//   per-axis valid bits and the pipeline clear together; no clearing pass.
module servo_power_up_and_motion_sequencer_unit
  import spmsu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // axis[5:0], position[37:6], zero pad
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  // result words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [71:0] m_tdata,   // axis_out[5:0], controlword[21:6],
                                      // target[53:22], op_mode[61:54],
                                      // power_state[64:62], sequence_done[65], pad
  // config writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Config registers; always ready.
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.motion_mode <= MODE_IDLE;
      cfg.spin_delta  <= 16'd50;
      cfg.spin_upper  <= 31'd100000;
      cfg.spin_margin <= 16'd200;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MOTION_MODE: cfg.motion_mode <= cfg_data[1:0];
        REG_SPIN_DELTA:  cfg.spin_delta  <= cfg_data[15:0];
        REG_SPIN_UPPER:  cfg.spin_upper  <= cfg_data[30:0];
        REG_SPIN_MARGIN: cfg.spin_margin <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stage 1 holds the item whose RAM read is in flight; the output register
  // decouples it from m_tready.
  logic              s1_v;
  logic [1:0]        s1_cmd;
  logic [5:0]        s1_axis;
  logic [31:0]       s1_actual;
  logic              o_v;
  logic              s_accept;
  logic              adv;

  assign adv      = s1_v && (!o_v || m_tready);
  assign s_tready = !s1_v || adv;
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = o_v;

  // Per-axis state memory plus valid bits (unwritten entries read as zero).
  logic [ENTRY_W-1:0] ram_q;
  logic [AXES-1:0]    vld;
  logic               wr_en;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_in_range;

  // Forward of the most recent write-back: covers a read issued in the
  // same cycle as a write to that axis.
  logic              fwd_v;
  logic [ADDR_W-1:0] fwd_addr;
  axis_entry_t       fwd_data;

  axis_entry_t old_entry;
  axis_entry_t new_entry;
  axis_entry_t res_entry;

  assign s1_addr     = axis_addr(s1_axis);
  assign s1_in_range = axis_in_range(s1_axis);
  assign wr_en       = adv && s1_in_range && (s1_cmd == CMD_POWER || s1_cmd == CMD_MOTION);

  spmsu_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(AXES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (new_entry),
    .rd_en   (s_accept),
    .rd_addr (axis_addr(s_tdata[5:0])),
    .rd_data (ram_q)
  );

  always_comb begin
    if (fwd_v && fwd_addr == s1_addr) begin
      old_entry = fwd_data;
    end else if (vld[s1_addr]) begin
      old_entry = axis_entry_t'(ram_q);
    end else begin
      old_entry = '0;
    end
  end

  logic [10:0] step;
  logic [10:0] step_next;

  always_comb begin
    step_next = step;
    case (s1_cmd)
      CMD_RESTART: step_next = '0;
      CMD_TICK:    step_next = (step < STEP_LAST) ? step + 11'd1 : step;
      default:     step_next = step;
    endcase
  end

  spmsu_update u_update (
    .cmd       (s1_cmd),
    .actual    (s1_actual),
    .step      (step),
    .cfg       (cfg),
    .old_entry (old_entry),
    .new_entry (new_entry)
  );

  assign res_entry = s1_in_range ? new_entry : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      o_v   <= 1'b0;
      fwd_v <= 1'b0;
      vld   <= '0;
      step  <= '0;
    end else begin
      if (s_accept) begin
        s1_v <= 1'b1;
      end else if (adv) begin
        s1_v <= 1'b0;
      end
      if (adv) begin
        o_v  <= 1'b1;
        step <= step_next;
      end else if (m_tready) begin
        o_v <= 1'b0;
      end
      if (wr_en) begin
        vld[s1_addr] <= 1'b1;
        fwd_v        <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_cmd    <= s_tuser;
      s1_axis   <= s_tdata[5:0];
      s1_actual <= s_tdata[37:6];
    end
    if (wr_en) begin
      fwd_addr <= s1_addr;
      fwd_data <= new_entry;
    end
    if (adv) begin
      m_tdata <= {6'd0,
                  (step_next >= STEP_LAST),
                  res_entry.phase,
                  res_entry.op_mode,
                  res_entry.target,
                  res_entry.control,
                  s1_axis};
    end
  end

  // Assertions
  a_step_sat: assert property (@(posedge clk) disable iff (rst) step <= STEP_LAST)
    else $error("step counter past saturation");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_cmd == CMD_RESTART) |=> (step == '0))
    else $error("restart did not clear step counter");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_v && o_v && !m_tready) |-> !s_tready)
    else $error("input taken while stage 1 is blocked");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[64:62] <= PH_SPIN))
    else $error("power_state out of range");

  a_fwd_valid: assert property (@(posedge clk) disable iff (rst)
    fwd_v |-> vld[fwd_addr])
    else $error("forwarded entry not marked valid");

endmodule
`default_nettype wire

FILE: bench/servo_power_up_and_motion_sequencer_unit_test.sv
`timescale 1ns / 1ps

module servo_power_up_and_motion_sequencer_unit_test;
  import spmsu_pkg::*;

  // motion modes with no name in the package: motion words leave the axis alone
  localparam logic [1:0] MODE_HOLD  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int IDLE_PCT    = 33;    // chance of a gap on either side, percent
  localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
  localparam int SETTLE      = 4;     // pipeline drain plus slack

  // one input word as queued; actual holds an offset when track is set
  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  axis;
    logic [31:0] actual;
    bit          track;   // actual = current target of the axis + offset
    bit          drain;   // hold this word until every result is back
    bit          steady;  // no gaps on either side around this word
  } command_word_t;

  // one result word, unpacked
  typedef struct {
    logic [5:0]  axis;
    logic [15:0] controlword;
    logic [31:0] target;
    logic [7:0]  op_mode;
    logic [2:0]  phase;
    logic        done;
  } drive_command_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // axis[5:0], position[37:6], zero pad
  logic [1:0]  s_tuser = '0;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // axis_out[5:0], controlword[21:6],
                               // target[53:22], op_mode[61:54],
                               // power_state[64:62], sequence_done[65], pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  servo_power_up_and_motion_sequencer_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer predictor: own copy of the registers and the per-axis store
  // ---------------------------------------------------------------------------
  logic [1:0]  mode_reg;
  logic [15:0] delta_reg;
  logic [30:0] upper_reg;
  logic [15:0] margin_reg;

  logic [10:0] step_reg;
  logic [31:0] target_mem  [AXES];
  logic [15:0] control_mem [AXES];
  logic [7:0]  op_mode_mem [AXES];
  logic        reverse_mem [AXES];
  logic [2:0]  phase_mem   [AXES];

  command_word_t  pending_words[$];
  drive_command_t expected_commands[$];
  command_word_t  in_flight;
  bit             steady_run = 1'b0;
  bit             steady_fill = 1'b0;

  int mismatches, words_sent, results_seen, reg_writes, drains;
  int turns_down, turns_up, band_holds, phase_writes, saturated_ticks;

  // applies one accepted word to the predicted state, returns the result word
  function automatic drive_command_t advance_sequencer(input command_word_t w);
    drive_command_t r;
    longint         pos;
    longint         backed;
    logic [15:0]    cw;
    logic [2:0]     ph;
    bit             hit;
    hit = (32'(w.axis) < AXES);
    pos = longint'($signed(w.actual));
    case (w.cmd)
      CMD_RESTART: step_reg = '0;
      CMD_TICK: begin
        if (step_reg < STEP_LAST) step_reg = step_reg + 11'd1;
        else saturated_ticks++;
      end
      CMD_POWER: begin
        // past the enable window the axis is left as it is
        if (hit && step_reg <= STEP_EN_END) begin
          if (step_reg <= STEP_RESET_END) begin
            cw = CW_FAULT_RESET;
            ph = PH_RESET;
          end else if (step_reg <= STEP_SHUT_END) begin
            cw = CW_SHUTDOWN;
            ph = PH_SHUTDOWN;
          end else if (step_reg <= STEP_SWON_END) begin
            cw = CW_SWITCH_ON;
            ph = PH_SWITCHON;
          end else begin
            cw = CW_ENABLE;
            ph = PH_ENABLE;
          end
          control_mem[w.axis] = cw;
          phase_mem[w.axis]   = ph;
          target_mem[w.axis]  = (ph == PH_RESET) ? '0 : w.actual;
          phase_writes++;
        end
      end
      default: begin
        if (hit && mode_reg == MODE_IDLE) begin
          // dead band: only a change above the low four bits moves the target
          if ((target_mem[w.axis] & DEADBAND_MASK) != (w.actual & DEADBAND_MASK))
            target_mem[w.axis] = w.actual;
          else
            band_holds++;
        end else if (hit && mode_reg == MODE_SPIN) begin
          phase_mem[w.axis]   = PH_SPIN;
          control_mem[w.axis] = CW_ENABLE;
          op_mode_mem[w.axis] = OPMODE_SPIN;
          if (!reverse_mem[w.axis]) begin
            if (pos + longint'(margin_reg) >= longint'(upper_reg)) begin
              target_mem[w.axis]  = w.actual - BACKOFF;
              reverse_mem[w.axis] = 1'b1;
              turns_down++;
            end else begin
              target_mem[w.axis] = w.actual + 32'(delta_reg);
            end
          end else begin
            if (pos <= longint'(margin_reg)) begin
              backed = pos - longint'(BACKOFF);
              target_mem[w.axis]  = (backed < 0) ? '0 : 32'(backed);
              reverse_mem[w.axis] = 1'b0;
              turns_up++;
            end else begin
              target_mem[w.axis] = w.actual - 32'(delta_reg);
            end
          end
        end
      end
    endcase
    r.axis        = w.axis;
    r.controlword = hit ? control_mem[w.axis] : '0;
    r.target      = hit ? target_mem[w.axis] : '0;
    r.op_mode     = hit ? op_mode_mem[w.axis] : '0;
    r.phase       = hit ? phase_mem[w.axis] : '0;
    r.done        = (step_reg >= STEP_LAST);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued words, predicts each one as it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    command_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_commands.push_back(advance_sequencer(in_flight));
        words_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0
            && !(pending_words[0].drain && expected_commands.size() != 0)
            && (pending_words[0].steady || $urandom_range(99) >= IDLE_PCT)) begin
          w = pending_words.pop_front();
          // closed loop: feed back the target the axis holds right now
          if (w.track && 32'(w.axis) < AXES) w.actual = target_mem[w.axis] + w.actual;
          if (w.drain) drains++;
          in_flight  = w;
          s_tvalid   <= 1'b1;
          s_tuser    <= w.cmd;
          s_tdata    <= {2'b00, w.actual, w.axis};
          steady_run <= w.steady;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, field-by-field check against the oldest word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    drive_command_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_commands.size() == 0) begin
          report_mismatch($sformatf("result word %0h with nothing outstanding", m_tdata));
        end else begin
          want = expected_commands.pop_front();
          if (m_tdata[5:0] !== want.axis)
            report_mismatch($sformatf("axis_out %0h, want %0h", m_tdata[5:0], want.axis));
          if (m_tdata[21:6] !== want.controlword)
            report_mismatch($sformatf("axis %0d controlword %0h, want %0h",
                                      want.axis, m_tdata[21:6], want.controlword));
          if (m_tdata[53:22] !== want.target)
            report_mismatch($sformatf("axis %0d target %0h, want %0h",
                                      want.axis, m_tdata[53:22], want.target));
          if (m_tdata[61:54] !== want.op_mode)
            report_mismatch($sformatf("axis %0d op_mode %0h, want %0h",
                                      want.axis, m_tdata[61:54], want.op_mode));
          if (m_tdata[64:62] !== want.phase)
            report_mismatch($sformatf("axis %0d power_state %0d, want %0d",
                                      want.axis, m_tdata[64:62], want.phase));
          if (m_tdata[65] !== want.done)
            report_mismatch($sformatf("axis %0d sequence_done %b, want %b",
                                      want.axis, m_tdata[65], want.done));
        end
      end
      m_tready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // watchdog: any handshake on any channel counts as progress
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("servo_power_up_and_motion_sequencer_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_word(input logic [1:0] cmd, input logic [5:0] axis,
                            input logic [31:0] actual, input bit track = 1'b0);
    command_word_t w;
    w.cmd    = cmd;
    w.axis   = axis;
    w.actual = actual;
    w.track  = track;
    w.drain  = 1'b0;
    w.steady = steady_fill;
    pending_words.push_back(w);
  endtask

  // positions biased toward the sign edges and the sweep turnaround points
  function automatic logic [31:0] pick_position();
    logic [31:0] jitter;
    jitter = 32'($urandom_range(0, 40)) - 32'd20;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return jitter;
      2: return 32'h7fff_ffff - 32'($urandom_range(0, 20));
      3: return 32'h8000_0000 + 32'($urandom_range(0, 20));
      4: return {1'b0, upper_reg} - 32'(margin_reg) + jitter;
      default: return 32'(margin_reg) + jitter;
    endcase
  endfunction

  // register writes happen only with the block drained
  task automatic write_register(input logic [7:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_MOTION_MODE: mode_reg   = value[1:0];
      REG_SPIN_DELTA:  delta_reg  = value[15:0];
      REG_SPIN_UPPER:  upper_reg  = value[30:0];
      REG_SPIN_MARGIN: margin_reg = value[15:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [15:0] delta,
                            input logic [30:0] upper, input logic [15:0] margin);
    write_register(REG_MOTION_MODE, 32'(mode));
    write_register(REG_SPIN_DELTA, 32'(delta));
    write_register(REG_SPIN_UPPER, 32'(upper));
    write_register(REG_SPIN_MARGIN, 32'(margin));
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || s_tvalid || expected_commands.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly closed-loop motion on a few axes, with noise and sequence words mixed in
  task automatic queue_mixed(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 60)
        queue_word(CMD_MOTION, 6'($urandom_range(0, 3)),
                   32'($urandom_range(0, 16)) - 32'd8, 1'b1);
      else if (r < 72)
        queue_word(CMD_MOTION, 6'($urandom_range(0, 63)), pick_position());
      else if (r < 82)
        queue_word(CMD_POWER, 6'($urandom_range(0, 63)), pick_position());
      else if (r < 92)
        queue_word(CMD_TICK, 6'($urandom_range(0, 63)), $urandom);
      else
        queue_word(CMD_RESTART, 6'($urandom_range(0, 63)), $urandom);
      if (i == count / 2) pending_words[$].drain = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int steps;
    int r;
    mode_reg   = MODE_IDLE;
    delta_reg  = 16'd50;
    upper_reg  = 31'd100000;
    margin_reg = 16'd200;
    step_reg   = '0;
    for (int a = 0; a < AXES; a++) begin
      target_mem[a]  = '0;
      control_mem[a] = '0;
      op_mode_mem[a] = '0;
      reverse_mem[a] = 1'b0;
      phase_mem[a]   = '0;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, reset configuration (idle tracking, step 0)
    queue_word(CMD_MOTION, 6'd0, 32'h0000_000f);   // inside the dead band
    queue_word(CMD_MOTION, 6'd0, 32'h0000_0010);   // just outside
    queue_word(CMD_MOTION, 6'd0, 32'h0000_001f);   // inside again
    queue_word(CMD_MOTION, 6'd63, 32'h7fff_ffff);
    queue_word(CMD_MOTION, 6'd63, 32'h8000_0000);
    queue_word(CMD_MOTION, 6'd1, 32'hffff_ffff);
    queue_word(CMD_POWER, 6'd0, 32'h1234_5678);    // fault reset forces target 0
    queue_word(CMD_POWER, 6'd63, 32'h8000_0000);
    queue_word(CMD_TICK, 6'd2, 32'h0);
    queue_word(CMD_POWER, 6'd2, 32'h7fff_ffff);
    queue_word(CMD_RESTART, 6'd2, 32'hffff_ffff);
    queue_word(CMD_TICK, 6'd3, 32'h0);
    queue_word(CMD_TICK, 6'd3, 32'h0);
    queue_word(CMD_RESTART, 6'd63, 32'h0);
    queue_word(CMD_MOTION, 6'd0, 32'hffff_fff0);
    wait_drained();

    // directed spin with the reset sweep limits
    write_register(REG_MOTION_MODE, 32'(MODE_SPIN));
    queue_word(CMD_MOTION, 6'd5, 32'd0);           // upward step
    queue_word(CMD_MOTION, 6'd5, 32'd99800);       // hits the limit, turns down
    queue_word(CMD_MOTION, 6'd5, 32'd5000);        // downward step
    queue_word(CMD_MOTION, 6'd5, 32'd200);         // at the margin, turns up
    queue_word(CMD_MOTION, 6'd6, 32'd99799);       // one short of the limit
    queue_word(CMD_MOTION, 6'd6, 32'd100000);
    queue_word(CMD_MOTION, 6'd6, 32'd5);           // back-off clamps at zero
    queue_word(CMD_MOTION, 6'd7, 32'h8000_0000);   // most negative going up
    queue_word(CMD_POWER, 6'd5, 32'd777);          // power-up over a spinning axis
    queue_word(CMD_MOTION, 6'd8, 32'h7fff_ffff);
    queue_word(CMD_MOTION, 6'd8, 32'h8000_0000);   // negative turnaround clamps
    wait_drained();

    // full power-up walk in idle tracking: restart, ticks to saturation with
    // power-up words landing on both sides of every window edge
    write_register(REG_MOTION_MODE, 32'(MODE_IDLE));
    queue_word(CMD_RESTART, 6'd0, 32'h0);
    steps = 0;
    while (steps < 1210) begin
      steady_fill = (steps >= 300 && steps < 700);
      r = $urandom_range(99);
      if (r < 88) begin
        queue_word(CMD_TICK, 6'($urandom_range(0, 63)), $urandom);
        steps++;
        if (steps == 500) pending_words[$].drain = 1'b1;
        if (steps == 400 || steps == 401 || steps == 600 || steps == 601 ||
            steps == 800 || steps == 801 || steps == 1000 || steps == 1001 ||
            steps == 1200)
          queue_word(CMD_POWER, 6'($urandom_range(0, 63)), pick_position());
      end else if (r < 94) begin
        queue_word(CMD_POWER, 6'($urandom_range(0, 63)), pick_position());
      end else begin
        queue_word(CMD_MOTION, 6'($urandom_range(0, 7)),
                   32'($urandom_range(0, 48)) - 32'd24, 1'b1);
      end
    end
    steady_fill = 1'b0;
    queue_word(CMD_POWER, 6'd9, 32'h0bad_f00d);    // past the window: unchanged
    queue_word(CMD_RESTART, 6'd9, 32'h0);           // done drops
    queue_word(CMD_POWER, 6'd9, 32'h0bad_f00d);
    wait_drained();

    // register settings, extremes included, each with a mixed burst
    set_config(MODE_SPIN, 16'd300, 31'd1000, 16'd200);
    queue_mixed(30);
    wait_drained();
    set_config(MODE_SPIN, 16'hffff, 31'h7fff_ffff, 16'hffff);
    queue_mixed(30);
    wait_drained();
    set_config(MODE_SPIN, 16'd0, 31'd0, 16'd0);
    queue_mixed(30);
    wait_drained();
    set_config(MODE_SPIN, 16'($urandom_range(1, 2000)), 31'($urandom_range(0, 5000)),
               16'($urandom_range(0, 1500)));
    queue_mixed(30);
    wait_drained();
    set_config(MODE_IDLE, 16'd50, 31'd100000, 16'd200);
    queue_mixed(30);
    wait_drained();
    set_config(MODE_HOLD, 16'($urandom), 31'($urandom), 16'($urandom));
    queue_mixed(30);
    wait_drained();
    set_config(MODE_SPARE, 16'($urandom), 31'($urandom), 16'($urandom));
    queue_mixed(30);
    wait_drained();
    set_config(MODE_SPIN, 16'($urandom), 31'($urandom), 16'($urandom));
    queue_mixed(30);
    wait_drained();

    $display("covered %0d input words, %0d result words, %0d register writes, %0d drains",
             words_sent, results_seen, reg_writes, drains);
    $display("power-up writes %0d, band holds %0d, turns %0d down / %0d up, %0d capped ticks",
             phase_writes, band_holds, turns_down, turns_up, saturated_ticks);
    if (mismatches == 0 && expected_commands.size() == 0) begin
      $display("servo_power_up_and_motion_sequencer_unit regression: pass");
    end else begin
      $display("servo_power_up_and_motion_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule
